FILE: design/dbtf_pkg.sv
// Shared types and constants for the deadband telemetry framer.
// Used by the front end, the descriptor queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dbtf_pkg;

    // Stream and configuration widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int VALUE_W = 16;
    localparam int ID_W = 8;
    localparam int TIME_W = 32;
    localparam int BYTE_W = 8;

    // Request modes carried in s_tuser
    localparam logic [S_TUSER_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [S_TUSER_W-1:0] MODE_WORD   = 2'd1;
    localparam logic [S_TUSER_W-1:0] MODE_IDONLY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_ID = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCURACY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 2'd2;

    // Configuration reset values
    localparam logic [ID_W-1:0]    RST_SENSOR_ID = 8'd0;
    localparam logic [VALUE_W-1:0] RST_ACCURACY  = 16'd2;
    localparam logic [TIME_W-1:0]  RST_PERIOD    = 32'd1000;

    // State reset values: empty window, so no sample value lies inside it at first
    localparam logic [VALUE_W-1:0] RST_WIN_LOW  = 16'hFFFF;
    localparam logic [VALUE_W-1:0] RST_WIN_HIGH = 16'h0000;
    localparam logic [TIME_W-1:0]  RST_NEXT_TIME = 32'd0;

    // Frame constants
    localparam logic [BYTE_W-1:0] FRAME_START = 8'hCA;
    localparam logic [BYTE_W-1:0] LEN_WORD    = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_IDONLY  = 8'd1;

    // Byte positions within a frame
    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] POS_START    = 3'd0;
    localparam logic [POS_W-1:0] POS_LEN      = 3'd1;
    localparam logic [POS_W-1:0] POS_ID       = 3'd2;
    localparam logic [POS_W-1:0] POS_HI       = 3'd3;
    localparam logic [POS_W-1:0] POS_LO       = 3'd4;
    localparam logic [POS_W-1:0] POS_WORD_LRC = 3'd5;
    localparam logic [POS_W-1:0] POS_ID_LRC   = 3'd3;

    // Descriptor queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Frame kind decided by the front end
    typedef enum logic [1:0] {
        FRM_NONE = 2'd0,
        FRM_ID   = 2'd1,
        FRM_WORD = 2'd2
    } frm_kind_t;

    // One queued frame request
    typedef struct packed {
        frm_kind_t          kind;
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
    } frm_desc_t;

endpackage

`default_nettype wire

FILE: design/dbtf_front.sv
// Front end: configuration registers, deadband and rate qualification, state update.
// Depends on dbtf_pkg; pushes one frame descriptor per accepted beat.
`timescale 1ns / 1ps
`default_nettype none

module dbtf_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [dbtf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire  [dbtf_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [dbtf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [dbtf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              push,
    output dbtf_pkg::frm_desc_t               push_desc,
    input  wire                               q_not_full
);
    import dbtf_pkg::*;

    logic [ID_W-1:0]    sensor_id_reg;
    logic [VALUE_W-1:0] accuracy_reg;
    logic [TIME_W-1:0]  period_reg;
    logic [VALUE_W-1:0] win_low_reg, win_low_next;
    logic [VALUE_W-1:0] win_high_reg, win_high_next;
    logic [TIME_W-1:0]  next_time_reg, next_time_next;

    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    req_id;
    logic [TIME_W-1:0]  time_now;
    logic               accept;
    logic               in_window;
    logic               due;
    logic               qualified;
    logic [VALUE_W:0]   high_sum;

    // Unpack the input beat
    assign value    = s_tdata[VALUE_W-1:0];
    assign req_id   = s_tdata[VALUE_W+ID_W-1:VALUE_W];
    assign time_now = s_tdata[VALUE_W+ID_W+TIME_W-1:VALUE_W+ID_W];

    assign s_tready  = q_not_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && q_not_full;
    assign push      = accept;

    // Qualify the sample against window and rate limit
    assign in_window = (win_low_reg <= value) && (value <= win_high_reg);
    assign due       = time_now > next_time_reg;
    assign qualified = (s_tuser == MODE_SAMPLE) && !in_window && due;
    assign high_sum  = {1'b0, value} + {1'b0, accuracy_reg};

    // Build the descriptor
    always_comb
    begin
        push_desc.value = value;
        push_desc.id    = req_id;
        push_desc.kind  = FRM_NONE;
        case (s_tuser)
            MODE_SAMPLE:
            begin
                push_desc.id   = sensor_id_reg;
                push_desc.kind = qualified ? FRM_WORD : FRM_NONE;
            end
            MODE_WORD:   push_desc.kind = FRM_WORD;
            MODE_IDONLY: push_desc.kind = FRM_ID;
            default:     push_desc.kind = FRM_NONE;
        endcase
    end

    // Recentre window and advance next time on a qualified sample
    always_comb
    begin
        win_low_next   = win_low_reg;
        win_high_next  = win_high_reg;
        next_time_next = next_time_reg;
        if (accept && qualified)
        begin
            win_low_next   = (value >= accuracy_reg) ? (value - accuracy_reg) : '0;
            win_high_next  = high_sum[VALUE_W] ? '1 : high_sum[VALUE_W-1:0];
            next_time_next = time_now + period_reg;
        end
    end

    // Hold state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_id_reg <= RST_SENSOR_ID;
            accuracy_reg  <= RST_ACCURACY;
            period_reg    <= RST_PERIOD;
            win_low_reg   <= RST_WIN_LOW;
            win_high_reg  <= RST_WIN_HIGH;
            next_time_reg <= RST_NEXT_TIME;
        end
        else
        begin
            win_low_reg   <= win_low_next;
            win_high_reg  <= win_high_next;
            next_time_reg <= next_time_next;
            if (cfg_valid)
            begin
                case (cfg_addr)
                    CFG_SENSOR_ID: sensor_id_reg <= cfg_data[ID_W-1:0];
                    CFG_ACCURACY:  accuracy_reg  <= cfg_data[VALUE_W-1:0];
                    CFG_PERIOD:    period_reg    <= cfg_data[TIME_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/dbtf_queue.sv
// Short descriptor queue between the front and back ends.
// Depends on dbtf_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dbtf_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  dbtf_pkg::frm_desc_t  push_desc,
    input  wire                  pop,
    output dbtf_pkg::frm_desc_t  head,
    output logic                 not_empty,
    output logic                 not_full
);
    import dbtf_pkg::*;

    frm_desc_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QDEPTH));
    assign head      = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed descriptor
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

FILE: design/dbtf_back.sv
// Back end: serializes queued frame descriptors into bytes with XOR LRC.
// Depends on dbtf_pkg; drives the registered output stream.
`timescale 1ns / 1ps
`default_nettype none

module dbtf_back (
    input  wire                               clk,
    input  wire                               rst_n,
    input  dbtf_pkg::frm_desc_t               head,
    input  wire                               q_not_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [dbtf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic [dbtf_pkg::M_TUSER_W-1:0]    m_tuser
);
    import dbtf_pkg::*;

    logic               active_reg, active_next;
    logic               out_valid_reg, out_valid_next;
    frm_desc_t          desc_reg;
    logic [POS_W-1:0]   idx_reg;
    logic [BYTE_W-1:0]  lrc_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic               out_bvalid_reg;
    logic               out_sent_reg;

    frm_desc_t          src;
    logic [POS_W-1:0]   idx_cur;
    logic [BYTE_W-1:0]  lrc_cur;
    logic               have;
    logic               advance;
    logic               fire;
    logic [BYTE_W-1:0]  cur_byte;
    logic               cur_last;
    logic               cur_bvalid;

    // Continue the current frame or start the one at the queue head
    assign src     = active_reg ? desc_reg : head;
    assign idx_cur = active_reg ? idx_reg : '0;
    assign lrc_cur = active_reg ? lrc_reg : '0;
    assign have    = active_reg || q_not_empty;
    assign advance = !out_valid_reg || m_tready;
    assign fire    = advance && have;
    assign pop     = fire && !active_reg;

    // Pick the byte at the current position
    always_comb
    begin
        cur_byte   = '0;
        cur_last   = 1'b1;
        cur_bvalid = 1'b1;
        case (src.kind)
            FRM_WORD:
            begin
                cur_last = (idx_cur == POS_WORD_LRC);
                case (idx_cur)
                    POS_START: cur_byte = FRAME_START;
                    POS_LEN:   cur_byte = LEN_WORD;
                    POS_ID:    cur_byte = src.id;
                    POS_HI:    cur_byte = src.value[VALUE_W-1:BYTE_W];
                    POS_LO:    cur_byte = src.value[BYTE_W-1:0];
                    default:   cur_byte = lrc_cur;
                endcase
            end
            FRM_ID:
            begin
                cur_last = (idx_cur == POS_ID_LRC);
                case (idx_cur)
                    POS_START: cur_byte = FRAME_START;
                    POS_LEN:   cur_byte = LEN_IDONLY;
                    POS_ID:    cur_byte = src.id;
                    default:   cur_byte = lrc_cur;
                endcase
            end
            default:
            begin
                cur_bvalid = 1'b0;
            end
        endcase
    end

    // Track the frame in progress and the output register
    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = fire;
        if (fire)
            active_next = !cur_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the next beat and the running LRC
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            desc_reg       <= src;
            idx_reg        <= idx_cur + 1'b1;
            lrc_reg        <= lrc_cur ^ cur_byte;
            out_byte_reg   <= cur_byte;
            out_last_reg   <= cur_last;
            out_bvalid_reg <= cur_bvalid;
            out_sent_reg   <= (src.kind != FRM_NONE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_sent_reg, out_bvalid_reg};

endmodule

`default_nettype wire

FILE: design/deadband_rate_limited_telemetry_framer.sv
// Deadband, rate-limited telemetry framer with XOR LRC framing.
// Depends on dbtf_pkg, dbtf_front, dbtf_queue and dbtf_back.
//
// Usage:
//   Input stream (s_*): one beat per request; s_tuser is the mode (sample,
//   word frame, id-only frame). Output stream (m_*): one beat per frame byte;
//   m_tlast marks the final beat of each request.
//   Config channel (cfg_*): cfg_addr selects sensor id, accuracy or
//   sample interval; cfg_ready is always high. Write only while idle.
//   Throughput: the back end emits one beat per cycle while m_tready is high;
//   a word frame has 6 beats, an id-only frame 4 and a rejected sample 1, so
//   the serializer sets the sustained rate. A four-entry descriptor queue lets
//   the front end keep accepting while the back end is busy; s_tready drops
//   only when it is full.
//   Reset clears the window to empty, next time to zero and the config
//   registers to 0, 2 and 1000. When m_tready is low the output beat holds and
//   the queue fills, then the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module deadband_rate_limited_telemetry_framer (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // value [15:0], req_id [23:16], time_now [55:24]
    input  wire  [dbtf_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode [1:0]
    input  wire  [dbtf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // out_byte [7:0]
    output logic [dbtf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // byte_valid [0], sent [1]
    output logic [dbtf_pkg::M_TUSER_W-1:0]    m_tuser,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [dbtf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [dbtf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dbtf_pkg::*;

    frm_desc_t push_desc;
    frm_desc_t head;
    logic      push;
    logic      pop;
    logic      q_not_empty;
    logic      q_not_full;

    // Qualify requests
    dbtf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_desc  (push_desc),
        .q_not_full (q_not_full)
    );

    // Buffer descriptors
    dbtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    // Serialize frames
    dbtf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

FILE: design/dbtf_checker.sv
// Port-level checks for the telemetry framer, bound to the top level.
// Depends on dbtf_pkg and deadband_rate_limited_telemetry_framer.
`timescale 1ns / 1ps
`default_nettype none

module dbtf_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [dbtf_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire                               m_tlast,
    input wire [dbtf_pkg::M_TUSER_W-1:0]     m_tuser
);
    import dbtf_pkg::*;

    // No output beat in the cycle after reset is seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output beat changed");

    // An empty beat is a lone final beat with nothing sent
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && (m_tdata == '0))
        else $error("malformed empty beat");

    // A frame directly after a finished request opens with the start byte
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=>
            !(m_tvalid && m_tuser[0]) || (m_tdata == FRAME_START))
        else $error("frame does not open with start byte");

    // Inside a frame every beat is a sent frame byte
    a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser[0] && m_tuser[1]))
        else $error("non-frame beat inside a frame");

endmodule

bind deadband_rate_limited_telemetry_framer dbtf_checker u_dbtf_checker (.*);

`default_nettype wire
